/* src/asp_pkg.sv */
// Shared types, constants and tables for the analog stick polar register block.
// Used by asp_front, asp_cordic, asp_back and the top level; no dependencies.
`default_nettype none
package asp_pkg;

    localparam logic [15:0] OPEN_BUS_HALF = 16'hAFFF;
    localparam logic [7:0]  ADDR_TOP      = 8'h09;
    localparam int          CORDIC_STEPS  = 20;
    localparam int          PRESHIFT      = 14;
    localparam int          QUEUE_DEPTH   = 2;
    localparam int          CW_BITS       = 34;  // CORDIC x/y datapath
    localparam int          ZW_BITS       = 24;  // angle accumulator, 2^21 per pi

    typedef enum logic {KIND_SET, KIND_READ} t_kind;
    typedef enum logic [1:0] {SZ_BYTE, SZ_HALF, SZ_WORD} t_size;
    typedef enum logic [2:0] {HS_OPEN, HS_X, HS_Y, HS_MAG, HS_ANG} t_hsel;
    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_SUM, ST_CHK, ST_DIV, ST_ROOT, ST_FIN} t_state;
    typedef enum logic [1:0] {PH_MAG, PH_X, PH_Y} t_phase;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        t_hsel              lo_sel;
        t_hsel              hi_sel;
        logic               byte_hi;
        t_size              size;
    } t_cmd;

    function automatic t_hsel decode_half(input logic [31:0] addr);
        t_hsel s;
        s = HS_OPEN;
        if (addr[31:24] == ADDR_TOP) begin
            if (addr[23:8] == 16'd0) begin
                case (addr[7:0])
                    8'h08:   s = HS_X;
                    8'h0A:   s = HS_Y;
                    default: s = HS_OPEN;
                endcase
            end else if (addr[23:8] == 16'd1) begin
                case (addr[7:0])
                    8'h00:   s = HS_MAG;
                    8'h02:   s = HS_X;
                    8'h04:   s = HS_Y;
                    8'h06:   s = HS_ANG;
                    default: s = HS_OPEN;
                endcase
            end
        end
        return s;
    endfunction

    // atan(2^-i), 2^21 units per pi
    function automatic logic signed [ZW_BITS-1:0] atan_tab(input logic [4:0] i);
        logic signed [ZW_BITS-1:0] v;
        case (i)
            5'd0:    v = 24'sd524288;
            5'd1:    v = 24'sd309505;
            5'd2:    v = 24'sd163534;
            5'd3:    v = 24'sd83012;
            5'd4:    v = 24'sd41667;
            5'd5:    v = 24'sd20854;
            5'd6:    v = 24'sd10430;
            5'd7:    v = 24'sd5215;
            5'd8:    v = 24'sd2608;
            5'd9:    v = 24'sd1304;
            5'd10:   v = 24'sd652;
            5'd11:   v = 24'sd326;
            5'd12:   v = 24'sd163;
            5'd13:   v = 24'sd81;
            5'd14:   v = 24'sd41;
            5'd15:   v = 24'sd20;
            5'd16:   v = 24'sd10;
            5'd17:   v = 24'sd5;
            5'd18:   v = 24'sd3;
            5'd19:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/asp_front.sv */
// Front end: accepts items, decodes read addresses into register selects,
// and holds classified commands in a short queue. Depends on asp_pkg.
`default_nettype none
module asp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic           i_func,
    input  wire logic [15:0]    i_x,
    input  wire logic [15:0]    i_y,
    input  wire logic [31:0]    i_addr,
    input  wire logic [1:0]     i_size,
    output logic                o_cmd_valid,
    output asp_pkg::t_cmd       o_cmd,
    input  wire logic           i_cmd_pop
);
    localparam int PW = $clog2(asp_pkg::QUEUE_DEPTH);

    asp_pkg::t_cmd   r_q [asp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    asp_pkg::t_cmd   n_cmd;
    logic            push;

    always_comb begin
        n_cmd         = '0;
        n_cmd.kind    = i_func ? asp_pkg::KIND_READ : asp_pkg::KIND_SET;
        n_cmd.x       = i_x;
        n_cmd.y       = i_y;
        n_cmd.hi_sel  = asp_pkg::HS_OPEN;
        n_cmd.byte_hi = i_addr[0];
        case (i_size)
            2'd0: begin
                n_cmd.size   = asp_pkg::SZ_BYTE;
                n_cmd.lo_sel = asp_pkg::decode_half({i_addr[31:1], 1'b0});
            end
            2'd1: begin
                n_cmd.size   = asp_pkg::SZ_HALF;
                n_cmd.lo_sel = asp_pkg::decode_half(i_addr);
            end
            default: begin
                n_cmd.size   = asp_pkg::SZ_WORD;
                n_cmd.lo_sel = asp_pkg::decode_half(i_addr);
                n_cmd.hi_sel = asp_pkg::decode_half({i_addr[31:2], 1'b1, i_addr[0]});
            end
        endcase
    end

    assign o_ready     = (r_cnt != (PW+1)'(asp_pkg::QUEUE_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= r_rp + 1'b1;
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/asp_cordic.sv */
// Iterative CORDIC vectoring unit: atan2(x, y) from the +y axis, 2^15 per pi.
// One micro-rotation per cycle, CORDIC_STEPS in all. Depends on asp_pkg.
`default_nettype none
module asp_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    output logic                    o_done,
    output logic [15:0]             o_angle
);
    localparam int CW = asp_pkg::CW_BITS;
    localparam int ZW = asp_pkg::ZW_BITS;

    logic                 r_busy, r_zero;
    logic [4:0]           r_i;
    logic signed [CW-1:0] r_a, r_b;
    logic signed [ZW-1:0] r_z;
    logic signed [CW-1:0] a0, b0, da, db;
    logic signed [ZW-1:0] z_abs, z_rnd;

    always_comb begin
        a0 = CW'(i_y) <<< asp_pkg::PRESHIFT;
        b0 = CW'(i_x) <<< asp_pkg::PRESHIFT;
        da = r_b >>> r_i;
        db = r_a >>> r_i;
        z_abs = (r_z < 0) ? -r_z : r_z;
        z_rnd = (z_abs + ZW'(32)) >>> 6;
        if (r_zero) o_angle = '0;
        else if (r_z < 0) o_angle = 16'(-z_rnd);
        else o_angle = 16'(z_rnd);
    end

    assign o_done = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_i == 5'(asp_pkg::CORDIC_STEPS - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_zero <= (i_x == 16'sd0) && (i_y == 16'sd0);
            // pre-rotate by +-pi into the upper half plane
            if (a0 < 0) begin
                r_a <= -a0;
                r_b <= -b0;
                r_z <= (b0 >= 0) ? (asp_pkg::atan_tab(5'd0) <<< 2)
                                 : -(asp_pkg::atan_tab(5'd0) <<< 2);
            end else begin
                r_a <= a0;
                r_b <= b0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_b >= 0) begin
                r_a <= r_a + da;
                r_b <= r_b - db;
                r_z <= r_z + asp_pkg::atan_tab(r_i);
            end else begin
                r_a <= r_a - da;
                r_b <= r_b + db;
                r_z <= r_z - asp_pkg::atan_tab(r_i);
            end
        end
    end
endmodule
`default_nettype wire

/* src/asp_back.sv */
// Back end: runs set commands (squares, restoring divider, digit square root,
// CORDIC) and answers reads from the four registers. Depends on asp_pkg, asp_cordic.
`default_nettype none
module asp_back #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire asp_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_data
);
    localparam int QW  = 2*FRAC_BITS + 3;     // quotient bits
    localparam int SW  = 2*FRAC_BITS + 4;     // square root operand bits
    localparam int RTW = SW/2;                // root bits
    localparam int RW  = FRAC_BITS + 6;       // root remainder bits
    localparam int NW  = $clog2(QW + 1);
    localparam logic [31:0] ONE_SQ = 32'(1) << (2*FRAC_BITS);
    localparam logic [15:0] ONE    = 16'(1) << FRAC_BITS;

    asp_pkg::t_state     r_state, n_state;
    asp_pkg::t_phase     r_phase;
    logic signed [15:0]  r_x, r_y;
    logic [31:0]         r_xx, r_yy, r_sq;
    logic [32:0]         r_rem;
    logic [QW-1:0]       r_quo;
    logic [NW-1:0]       r_cnt;
    logic [SW-1:0]       r_op;
    logic [RW-1:0]       r_srem;
    logic [RTW-1:0]      r_root;
    logic [15:0]         r_pos_x, r_pos_y, r_mag, r_ang;
    logic [31:0]         r_odata;
    logic                r_ovalid;

    logic                out_free, take_read, take_set, div_last, root_last;
    logic [32:0]         dv_t;
    logic                dv_ge;
    logic [QW-1:0]       quo_next;
    logic [RW-1:0]       rt_sh, rt_trial;
    logic                rt_ge;
    logic [RTW-1:0]      root_next;
    logic [RTW-1:0]      rnd;
    logic [15:0]         n16;
    logic                cor_done;
    logic [15:0]         cor_angle;
    logic [15:0]         half_lo, half_hi;
    logic [31:0]         rd_data;

    function automatic logic [15:0] pick(input asp_pkg::t_hsel s, input logic [15:0] px,
                                         input logic [15:0] py, input logic [15:0] pm,
                                         input logic [15:0] pa);
        logic [15:0] v;
        case (s)
            asp_pkg::HS_X:   v = px;
            asp_pkg::HS_Y:   v = py;
            asp_pkg::HS_MAG: v = pm;
            asp_pkg::HS_ANG: v = pa;
            default:         v = asp_pkg::OPEN_BUS_HALF;
        endcase
        return v;
    endfunction

    asp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (take_set),
        .i_x     (i_cmd.x),
        .i_y     (i_cmd.y),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    // read decode
    always_comb begin
        half_lo = pick(i_cmd.lo_sel, r_pos_x, r_pos_y, r_mag, r_ang);
        half_hi = pick(i_cmd.hi_sel, r_pos_x, r_pos_y, r_mag, r_ang);
        case (i_cmd.size)
            asp_pkg::SZ_BYTE: rd_data = {24'd0, i_cmd.byte_hi ? half_lo[15:8] : half_lo[7:0]};
            asp_pkg::SZ_HALF: rd_data = {16'd0, half_lo};
            default:          rd_data = {half_hi, half_lo};
        endcase
    end

    // divider and square root steps
    always_comb begin
        dv_t      = (r_cnt == '0) ? {1'b0, r_rem[31:0]} : {r_rem[31:0], 1'b0};
        dv_ge     = dv_t >= {1'b0, r_sq};
        quo_next  = {r_quo[QW-2:0], dv_ge};
        rt_sh     = {r_srem[RW-3:0], r_op[SW-1:SW-2]};
        rt_trial  = RW'({r_root, 2'b01});
        rt_ge     = rt_sh >= rt_trial;
        root_next = {r_root[RTW-2:0], rt_ge};
        rnd       = (root_next + 1'b1) >> 1;
        n16       = 16'(rnd);
        div_last  = (r_cnt == NW'(QW - 1));
        root_last = (r_cnt == NW'(RTW - 1));
    end

    // control outputs
    always_comb begin
        out_free  = !r_ovalid || i_ready;
        take_read = 1'b0;
        take_set  = 1'b0;
        if (r_state == asp_pkg::ST_IDLE && i_cmd_valid) begin
            if (i_cmd.kind == asp_pkg::KIND_READ) take_read = out_free;
            else take_set = 1'b1;
        end
        o_cmd_pop = take_read || take_set;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            asp_pkg::ST_IDLE: if (take_set) n_state = asp_pkg::ST_MUL;
            asp_pkg::ST_MUL:  n_state = asp_pkg::ST_SUM;
            asp_pkg::ST_SUM:  n_state = asp_pkg::ST_CHK;
            asp_pkg::ST_CHK:  n_state = (r_sq > ONE_SQ) ? asp_pkg::ST_DIV : asp_pkg::ST_ROOT;
            asp_pkg::ST_DIV:  if (div_last) n_state = asp_pkg::ST_ROOT;
            asp_pkg::ST_ROOT: begin
                if (root_last) begin
                    n_state = (r_phase == asp_pkg::PH_X) ? asp_pkg::ST_DIV : asp_pkg::ST_FIN;
                end
            end
            asp_pkg::ST_FIN:  if (cor_done) n_state = asp_pkg::ST_IDLE;
            default:          n_state = asp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= asp_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_mag    <= '0;
            r_ang    <= '0;
        end else begin
            r_state <= n_state;
            if (take_read) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (r_state == asp_pkg::ST_ROOT && root_last) begin
                case (r_phase)
                    asp_pkg::PH_MAG: begin
                        r_mag   <= n16;
                        r_pos_x <= r_x;
                        r_pos_y <= r_y;
                    end
                    asp_pkg::PH_X: r_pos_x <= r_x[15] ? -n16 : n16;
                    default: begin
                        r_pos_y <= r_y[15] ? -n16 : n16;
                        r_mag   <= ONE;
                    end
                endcase
            end
            if (r_state == asp_pkg::ST_FIN && cor_done) r_ang <= cor_angle;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (take_read) r_odata <= rd_data;
        if (take_set) begin
            r_x <= i_cmd.x;
            r_y <= i_cmd.y;
        end
        case (r_state)
            asp_pkg::ST_MUL: begin
                r_xx <= 32'(r_x * r_x);
                r_yy <= 32'(r_y * r_y);
            end
            asp_pkg::ST_SUM: r_sq <= r_xx + r_yy;
            asp_pkg::ST_CHK: begin
                r_cnt  <= '0;
                r_quo  <= '0;
                r_srem <= '0;
                r_root <= '0;
                r_rem  <= {1'b0, r_xx};
                r_op   <= {r_sq[SW-3:0], 2'b00};
                r_phase <= (r_sq > ONE_SQ) ? asp_pkg::PH_X : asp_pkg::PH_MAG;
            end
            asp_pkg::ST_DIV: begin
                r_rem <= dv_ge ? dv_t - {1'b0, r_sq} : dv_t;
                r_quo <= quo_next;
                if (div_last) begin
                    r_cnt  <= '0;
                    r_op   <= SW'(quo_next);
                    r_srem <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            asp_pkg::ST_ROOT: begin
                r_srem <= rt_ge ? rt_sh - rt_trial : rt_sh;
                r_root <= root_next;
                r_op   <= {r_op[SW-3:0], 2'b00};
                if (root_last) begin
                    r_cnt <= '0;
                    r_quo <= '0;
                    r_rem <= {1'b0, r_yy};
                    if (r_phase == asp_pkg::PH_X) r_phase <= asp_pkg::PH_Y;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
endmodule
`default_nettype wire

/* src/analog_stick_polar_registers_top.sv */
// Read: an item is taken from the queue when the back end is idle and the output register
// is free. Set: squares, then a digit square root for the magnitude, or when scaled a
// restoring divider then a digit square root per coordinate; the CORDIC is waited for.
// Items queue two deep ahead of the back end; one set runs at a time.
// Synchronous active-low reset clears all four registers to zero and empties the queue.
// Depends on asp_pkg, asp_front, asp_back.
`default_nettype none
module analog_stick_polar_registers_top #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // stick_x[15:0], stick_y[31:16], bus_address[63:32], access_size[65:64], zero pad
    input  wire logic [71:0] i_s_axis_tdata,
    // func[0]
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // read_data[31:0]
    output logic [31:0]      o_m_axis_tdata
);
    logic          cmd_valid, cmd_pop;
    asp_pkg::t_cmd cmd;

    asp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_func      (i_s_axis_tuser),
        .i_x         (i_s_axis_tdata[15:0]),
        .i_y         (i_s_axis_tdata[31:16]),
        .i_addr      (i_s_axis_tdata[63:32]),
        .i_size      (i_s_axis_tdata[65:64]),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    asp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for analog_stick_polar_registers_top: polar conversion and
// register reads, predicted in-bench and compared item by item. Depends on asp_pkg.
`timescale 1ns / 100ps
module testbench;

    localparam int  ONE_Q       = 4096;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  DRAIN_WAIT  = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata;   // stick_x, stick_y, bus_address, access_size, pad
    logic        i_s_axis_tuser;   // func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // read_data

    analog_stick_polar_registers_top uut (.*);

    // predictor copy of the registers
    logic [15:0] reg_x, reg_y, reg_mag, reg_ang;
    logic [31:0] read_expect_q[$];
    int          errors;
    int          cycles;
    int          stall_left;
    bit          no_stall;

    longint atan_lut[asp_pkg::CORDIC_STEPS] = '{524288, 309505, 163534, 83012, 41667,
        20854, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] scale_to_unit(input longint c, input longint unsigned sq);
        longint unsigned a, q;
        longint n;
        a = (c < 0) ? -c : c;
        q = (4 * a * a * ONE_Q * ONE_Q) / sq;
        n = longint'((int_sqrt(q) + 1) / 2);
        return (c < 0) ? 16'(-n) : 16'(n);
    endfunction

    function automatic logic [15:0] polar_angle(input longint x, input longint y);
        longint a, b, z, da, db;
        a = y * 16384;
        b = x * 16384;
        z = 0;
        if (x == 0 && y == 0) return 16'h0;
        if (a < 0) begin
            z = (b >= 0) ? atan_lut[0] * 4 : -atan_lut[0] * 4;
            a = -a;
            b = -b;
        end
        for (int i = 0; i < asp_pkg::CORDIC_STEPS; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a += da; b -= db; z += atan_lut[i];
            end else begin
                a -= da; b += db; z -= atan_lut[i];
            end
        end
        if (z >= 0) return 16'((z + 32) >>> 6);
        return 16'(-((-z + 32) >>> 6));
    endfunction

    task automatic update_position(input logic signed [15:0] sx, input logic signed [15:0] sy);
        longint x, y;
        longint unsigned sq;
        x = sx;
        y = sy;
        sq = longint'(x * x + y * y);
        reg_ang = polar_angle(x, y);
        if (sq > ONE_Q * ONE_Q) begin
            reg_x   = scale_to_unit(x, sq);
            reg_y   = scale_to_unit(y, sq);
            reg_mag = 16'(ONE_Q);
        end else begin
            reg_x   = sx;
            reg_y   = sy;
            reg_mag = 16'((int_sqrt(4 * sq) + 1) / 2);
        end
    endtask

    function automatic logic [15:0] reg_half(input logic [31:0] addr);
        if (addr[31:24] != asp_pkg::ADDR_TOP) return asp_pkg::OPEN_BUS_HALF;
        if (addr[23:8] == 16'd0) begin
            case (addr[7:0])
                8'h08:   return reg_x;
                8'h0A:   return reg_y;
                default: return asp_pkg::OPEN_BUS_HALF;
            endcase
        end
        if (addr[23:8] == 16'd1) begin
            case (addr[7:0])
                8'h00:   return reg_mag;
                8'h02:   return reg_x;
                8'h04:   return reg_y;
                8'h06:   return reg_ang;
                default: return asp_pkg::OPEN_BUS_HALF;
            endcase
        end
        return asp_pkg::OPEN_BUS_HALF;
    endfunction

    function automatic logic [31:0] bus_read(input logic [31:0] addr, input logic [1:0] sz);
        logic [15:0] h;
        if (sz == asp_pkg::SZ_BYTE) begin
            h = reg_half({addr[31:1], 1'b0});
            return {24'h0, addr[0] ? h[15:8] : h[7:0]};
        end
        if (sz == asp_pkg::SZ_HALF) return {16'h0, reg_half(addr)};
        return {reg_half(addr | 32'h2), reg_half(addr)};
    endfunction

    // mostly zero, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(input asp_pkg::t_kind kind, input logic [15:0] sx,
                             input logic [15:0] sy, input logic [31:0] addr,
                             input logic [1:0] sz);
        int gap;
        i_s_axis_tdata  <= {6'h0, sz, addr, sy, sx};
        i_s_axis_tuser  <= kind;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind == asp_pkg::KIND_SET) update_position(sx, sy);
        else read_expect_q.push_back(bus_read(addr, sz));
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic set_pos(input logic [15:0] sx, input logic [15:0] sy);
        send_item(asp_pkg::KIND_SET, sx, sy, $urandom, 2'($urandom));
    endtask

    task automatic read_at(input logic [31:0] addr, input logic [1:0] sz);
        send_item(asp_pkg::KIND_READ, 16'($urandom), 16'($urandom), addr, sz);
    endtask

    task automatic dump_registers();
        read_at(32'h0900_0100, asp_pkg::SZ_WORD);
        read_at(32'h0900_0104, asp_pkg::SZ_WORD);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (read_expect_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                logic [31:0] want;
                want = read_expect_q.pop_front();
                if (o_m_axis_tdata !== want) begin
                    $display("%0t: read_data expected %h actual %h", $time, want,
                             o_m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    // receiver stalls of random length, switched off for stretches
    always @(posedge i_clk) begin
        if (no_stall) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            stall_left      <= pick_gap();
        end
    end

    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (read_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        dump_registers();
        read_at(32'h0900_0008, asp_pkg::SZ_WORD);
    endtask

    task automatic test_set_extremes();
        set_pos(16'h0000, 16'h0000);  dump_registers();
        set_pos(16'h8000, 16'h8000);  dump_registers();
        set_pos(16'h7FFF, 16'h7FFF);  dump_registers();
        set_pos(16'h0000, 16'hFFFF);  dump_registers();  // straight down, angle wraps
        set_pos(16'h1000, 16'h0000);  dump_registers();  // exactly unit length
        set_pos(16'hF000, 16'h0001);  dump_registers();  // just past unit
        set_pos(16'h0123, 16'hFF40);  dump_registers();
    endtask

    task automatic test_register_map();
        set_pos(16'h0A5C, 16'hF3C1);
        read_at(32'h0900_0008, asp_pkg::SZ_HALF);
        read_at(32'h0900_000A, asp_pkg::SZ_HALF);
        read_at(32'h0900_0106, asp_pkg::SZ_HALF);
        read_at(32'h0900_0009, asp_pkg::SZ_BYTE);    // odd byte
        read_at(32'h0900_0102, asp_pkg::SZ_BYTE);
        read_at(32'h0900_0103, asp_pkg::SZ_HALF);    // unaligned halfword
        read_at(32'h0900_0106, asp_pkg::SZ_WORD);    // high half repeats the angle
        read_at(32'h0900_0102, 2'd3);                // size three reads as word
        read_at(32'h0A00_0100, asp_pkg::SZ_HALF);    // wrong top byte
        read_at(32'h0902_0100, asp_pkg::SZ_WORD);    // wrong page
    endtask

    task automatic test_quiesce();
        wait_quiet();
        read_at(32'h0900_0100, asp_pkg::SZ_WORD);
    endtask

    task automatic test_random(input int count);
        logic [31:0] addr;
        int          r;
        for (int n = 0; n < count; n++) begin
            if (n % 200 == 0) no_stall = (n % 400 == 0);
            r = $urandom_range(0, 99);
            if (r < 30) begin
                r = $urandom_range(0, 3);
                if (r == 0) set_pos(16'($urandom), 16'($urandom));
                else if (r == 1) set_pos(16'($urandom_range(0, 8192) - 4096),
                                         16'($urandom_range(0, 8192) - 4096));
                else set_pos(16'($urandom_range(0, 5800) - 2900),
                             16'($urandom_range(0, 5800) - 2900));
            end else begin
                r = $urandom_range(0, 9);
                if (r < 2) addr = $urandom;
                else addr = {asp_pkg::ADDR_TOP, 15'h0, 1'($urandom), 4'h0,
                             4'($urandom_range(0, 11))};
                read_at(addr, 2'($urandom));
            end
        end
        no_stall = 1'b0;
    endtask

    initial begin
        errors          = 0;
        cycles          = 0;
        stall_left      = 0;
        no_stall        = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        reg_x = 0; reg_y = 0; reg_mag = 0; reg_ang = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_set_extremes();
        test_register_map();
        test_quiesce();
        test_random(800);
        test_quiesce();
        test_random(800);

        wait_quiet();
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

/* filelist.f */
src/asp_pkg.sv
src/asp_front.sv
src/asp_cordic.sv
src/asp_back.sv
src/analog_stick_polar_registers_top.sv
tb/sv/testbench.sv
